/* hw/rtl/qte_pkg.sv */
// Shared types, constants and arctangent table for the quaternion to Euler block.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

  localparam int unsigned FRAC_BITS     = 14;
  localparam int unsigned CORDIC_STAGES = 16;
  localparam int unsigned CORDIC_MAX    = 24;
  localparam int unsigned THR_W         = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd16382;

  // atan2 operand width and internal widths
  localparam int unsigned OPW  = 34;   // operand into the atan units
  localparam int unsigned C2W  = 2 * FRAC_BITS + 1;
  localparam int unsigned RTW  = FRAC_BITS + 1;
  localparam int unsigned SQRT_STAGES = FRAC_BITS + 1;
  localparam int unsigned FRONT_STAGES = 3;

  typedef enum logic {
    MODE_OBJ_TO_INR = 1'b0,
    MODE_INR_TO_OBJ = 1'b1
  } mode_e;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } in_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [15:0] pitch;
    logic signed [15:0] bank;
    logic               gimbal_lock;
  } out_t;

  // front end result handed to the sqrt and atan units
  typedef struct packed {
    logic signed [15:0]    sp;
    logic                  lock;
    logic [C2W-1:0]        c2;
    logic signed [OPW-1:0] hy;
    logic signed [OPW-1:0] hx;
    logic signed [OPW-1:0] by;
    logic signed [OPW-1:0] bx;
  } front_t;

  // atan(2^-i), 2^32 per turn
  localparam logic [31:0] ATAN_TAB [CORDIC_MAX] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage
`default_nettype wire

/* hw/rtl/qte_front.sv */
// Front end: quaternion products, sine of pitch, gimbal test and atan operands.
`timescale 1ns / 1ps
`default_nettype none
module qte_front (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire qte_pkg::in_t                    in_i,
  input  wire logic [qte_pkg::THR_W-1:0]       thr_i,
  output qte_pkg::front_t                      out_o
);

  localparam int unsigned F = qte_pkg::FRAC_BITS;
  localparam int unsigned W = qte_pkg::OPW;

  // stage 1: products
  logic signed [31:0] wx_q, wy_q, wz_q, yz_q, xz_q, xx_q, yy_q, zz_q, xy_q;
  logic signed [31:0] wx_d, wy_d, wz_d;

  always_comb begin
    wx_d = in_i.qw * in_i.qx;
    wy_d = in_i.qw * in_i.qy;
    wz_d = in_i.qw * in_i.qz;
    if (in_i.mode == qte_pkg::MODE_INR_TO_OBJ) begin
      wx_d = -wx_d;
      wy_d = -wy_d;
      wz_d = -wz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= wx_d;
      wy_q <= wy_d;
      wz_q <= wz_d;
      yz_q <= in_i.qy * in_i.qz;
      xz_q <= in_i.qx * in_i.qz;
      xx_q <= in_i.qx * in_i.qx;
      yy_q <= in_i.qy * in_i.qy;
      zz_q <= in_i.qz * in_i.qz;
      xy_q <= in_i.qx * in_i.qy;
    end
  end

  // stage 2: sums, rounded and clamped sine of pitch
  localparam logic signed [W-1:0] HALF2 = W'(1) <<< (2 * F - 1);
  localparam logic signed [W-1:0] ONE   = W'(1) <<< F;

  logic signed [W-1:0] spf, spr;
  logic signed [15:0]  sp_d, sp_q;
  logic signed [W-1:0] hyg_q, hxg_q, hyn_q, hxn_q, by_q, bx_q;

  always_comb begin
    spf = -W'(2) * (W'(yz_q) - W'(wx_q));
    spr = (spf + (W'(1) <<< (F - 1))) >>> F;
    if (spr > ONE) begin
      sp_d = 16'(ONE);
    end else if (spr < -ONE) begin
      sp_d = 16'(-ONE);
    end else begin
      sp_d = 16'(spr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q  <= sp_d;
      hyg_q <= W'(wy_q) - W'(xz_q);
      hxg_q <= HALF2 - W'(yy_q) - W'(zz_q);
      hyn_q <= W'(xz_q) + W'(wy_q);
      hxn_q <= HALF2 - W'(xx_q) - W'(yy_q);
      by_q  <= W'(xy_q) + W'(wz_q);
      bx_q  <= HALF2 - W'(xx_q) - W'(zz_q);
    end
  end

  // stage 3: gimbal test, 1 - sp^2, heading operand choice
  logic [14:0]              sp_mag;
  logic                     lock_d;
  logic [2*F+1:0]           sq;
  qte_pkg::front_t          out_q;

  always_comb begin
    sp_mag = (sp_q < 0) ? 15'(-sp_q) : 15'(sp_q);
    lock_d = sp_mag > thr_i;
    sq     = (2*F+2)'(sp_q * sp_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.sp   <= sp_q;
      out_q.lock <= lock_d;
      out_q.c2   <= qte_pkg::C2W'(((2*F+2)'(1) << (2 * F)) - sq);
      out_q.hy   <= lock_d ? hyg_q : hyn_q;
      out_q.hx   <= lock_d ? hxg_q : hxn_q;
      out_q.by   <= by_q;
      out_q.bx   <= bx_q;
    end
  end

  assign out_o = out_q;

endmodule
`default_nettype wire

/* hw/rtl/qte_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [qte_pkg::C2W-1:0]     v_i,
  output logic      [qte_pkg::RTW-1:0]     root_o
);

  localparam int unsigned N  = qte_pkg::SQRT_STAGES;
  localparam int unsigned RW = qte_pkg::RTW;
  localparam int unsigned SW = 2 * RW + 1;

  logic [qte_pkg::C2W-1:0] v_q    [N];
  logic [RW-1:0]           root_q [N];
  logic [SW-1:0]           sq_q   [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int unsigned B = N - 1 - s;
    logic [qte_pkg::C2W-1:0] v_in;
    logic [RW-1:0]           r_in;
    logic [SW-1:0]           s_in, trial;

    if (s == 0) begin : g_first
      assign v_in = v_i;
      assign r_in = '0;
      assign s_in = '0;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign r_in = root_q[s-1];
      assign s_in = sq_q[s-1];
    end

    // (r + 2^B)^2 = r^2 + r*2^(B+1) + 2^(2B)
    assign trial = s_in + (SW'(r_in) << (B + 1)) + (SW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[s] <= v_in;
        if (trial <= SW'(v_in)) begin
          root_q[s] <= r_in | (RW'(1) << B);
          sq_q[s]   <= trial;
        end else begin
          root_q[s] <= r_in;
          sq_q[s]   <= s_in;
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule
`default_nettype wire

/* hw/rtl/qte_atan.sv */
// Pipelined atan2: operand normalizer, half-turn fold and vectoring CORDIC.
`timescale 1ns / 1ps
`default_nettype none
module qte_atan #(
  parameter int unsigned CORDIC_STAGES = qte_pkg::CORDIC_STAGES
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [qte_pkg::OPW-1:0]    y_i,
  input  wire logic signed [qte_pkg::OPW-1:0]    x_i,
  output logic signed [15:0]                     ang_o
);

  localparam int unsigned NW = 42;  // normalized operand, |v| < 2^40
  localparam int unsigned MW = 40;
  localparam int unsigned CW = 44;  // CORDIC datapath with gain headroom

  // normalizer stage A: shifts of 32, 16, 8
  logic signed [NW-1:0] ax, ay, ax_q, ay_q;
  logic [MW-1:0]        am, am_q;
  logic                 az_q;

  always_comb begin
    ax = NW'(x_i);
    ay = NW'(y_i);
    am = MW'((x_i < 0) ? -NW'(x_i) : NW'(x_i)) | MW'((y_i < 0) ? -NW'(y_i) : NW'(y_i));
    for (int k = 32; k >= 8; k = k / 2) begin
      if ((am >> (MW - k)) == '0) begin
        ax = ax <<< k;
        ay = ay <<< k;
        am = am << k;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= ax;
      ay_q <= ay;
      am_q <= am;
      az_q <= (x_i == '0) && (y_i == '0);
    end
  end

  // normalizer stage B: shifts of 4, 2, 1
  logic signed [NW-1:0] bx, by, bx_q, by_q;
  logic [MW-1:0]        bm;
  logic                 bz_q;

  always_comb begin
    bx = ax_q;
    by = ay_q;
    bm = am_q;
    for (int k = 4; k >= 1; k = k / 2) begin
      if ((bm >> (MW - k)) == '0) begin
        bx = bx <<< k;
        by = by <<< k;
        bm = bm << k;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bx_q <= bx;
      by_q <= by;
      bz_q <= az_q;
    end
  end

  // fold into right half plane
  logic signed [CW-1:0] px_q, py_q;
  logic [31:0]          pz_q;
  logic                 pzero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pzero_q <= bz_q;
      if (bx_q < 0) begin
        px_q <= -CW'(bx_q);
        py_q <= -CW'(by_q);
        pz_q <= 32'h8000_0000;
      end else begin
        px_q <= CW'(bx_q);
        py_q <= CW'(by_q);
        pz_q <= '0;
      end
    end
  end

  // CORDIC rotations
  logic signed [CW-1:0] cx_q [CORDIC_STAGES];
  logic signed [CW-1:0] cy_q [CORDIC_STAGES];
  logic [31:0]          cz_q [CORDIC_STAGES];
  logic                 cn_q [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    logic signed [CW-1:0] xi, yi;
    logic [31:0]          zi;
    logic                 ni;

    if (i == 0) begin : g_first
      assign xi = px_q;
      assign yi = py_q;
      assign zi = pz_q;
      assign ni = pzero_q;
    end else begin : g_next
      assign xi = cx_q[i-1];
      assign yi = cy_q[i-1];
      assign zi = cz_q[i-1];
      assign ni = cn_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cn_q[i] <= ni;
        if (yi >= 0) begin
          cx_q[i] <= xi + (yi >>> i);
          cy_q[i] <= yi - (xi >>> i);
          cz_q[i] <= zi + qte_pkg::ATAN_TAB[i];
        end else begin
          cx_q[i] <= xi - (yi >>> i);
          cy_q[i] <= yi + (xi >>> i);
          cz_q[i] <= zi - qte_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  // round to binary angle units
  logic [31:0]        zr;
  logic signed [15:0] ang_q;

  assign zr = cz_q[CORDIC_STAGES-1] + 32'h0000_8000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= cn_q[CORDIC_STAGES-1] ? '0 : zr[31:16];
    end
  end

  assign ang_o = ang_q;

endmodule
`default_nettype wire

/* hw/rtl/quaternion_to_euler_angles.sv */
// Top level: quaternion to heading, pitch and bank, fully pipelined.
//
//  channel   dir  handshake                      payload
//  in        in   in_valid_i / in_ready_o        in_data_i  (qte_pkg::in_t)
//  out       out  out_valid_o / out_ready_i      out_data_o (qte_pkg::out_t)
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_data_i (gimbal threshold, Q1.14)
//
// One request per cycle sustained while the output is taken. A request passes the
// front end products/sums, one sqrt stage per root bit, then the
// normalizer, fold, one CORDIC stage per iteration and the rounding stage.
// Reset clears the valid chain and sets the threshold to 16382.
// When the output holds and is not taken, the whole pipe freezes in place.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_STAGES = qte_pkg::CORDIC_STAGES
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire qte_pkg::in_t                 in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output qte_pkg::out_t                     out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [qte_pkg::THR_W-1:0]    cfg_data_i
);

  localparam int unsigned SQL = qte_pkg::SQRT_STAGES;
  localparam int unsigned ATL = CORDIC_STAGES + 4;
  localparam int unsigned LAT = qte_pkg::FRONT_STAGES + SQL + ATL;

  // threshold register, always writable
  logic [qte_pkg::THR_W-1:0] thr_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= qte_pkg::THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // global advance: the last stage is the output register
  logic en;
  logic vld_q [LAT];

  assign en         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // front end
  qte_pkg::front_t fr;

  qte_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .in_i  (in_data_i),
    .thr_i (thr_q),
    .out_o (fr)
  );

  // cos(pitch) = sqrt(1 - sp^2)
  logic [qte_pkg::RTW-1:0] root;

  qte_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (fr.c2),
    .root_o (root)
  );

  // sp and lock follow the request to the output
  logic signed [15:0] sp_dq   [SQL + ATL];
  logic               lock_dq [SQL + ATL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_dq[0]   <= fr.sp;
      lock_dq[0] <= fr.lock;
      for (int i = 1; i < SQL + ATL; i++) begin
        sp_dq[i]   <= sp_dq[i-1];
        lock_dq[i] <= lock_dq[i-1];
      end
    end
  end

  // heading and bank start right after the front end
  logic signed [15:0] head_a, bank_a, pitch_a;

  qte_atan #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan_head (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (fr.hy),
    .x_i   (fr.hx),
    .ang_o (head_a)
  );

  qte_atan #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan_bank (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (fr.by),
    .x_i   (fr.bx),
    .ang_o (bank_a)
  );

  // pitch = atan2(sp, cos) once the root is out
  qte_atan #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (qte_pkg::OPW'(sp_dq[SQL-1])),
    .x_i   (qte_pkg::OPW'(root)),
    .ang_o (pitch_a)
  );

  // line up heading and bank with pitch
  logic signed [15:0] head_dq [SQL];
  logic signed [15:0] bank_dq [SQL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      head_dq[0] <= head_a;
      bank_dq[0] <= bank_a;
      for (int i = 1; i < SQL; i++) begin
        head_dq[i] <= head_dq[i-1];
        bank_dq[i] <= bank_dq[i-1];
      end
    end
  end

  // under gimbal lock pitch is sp in quarter turns (exact for Q1.14), bank zero
  logic out_lock;
  assign out_lock = lock_dq[SQL + ATL - 1];

  assign out_valid_o            = vld_q[LAT-1];
  assign out_data_o.heading     = head_dq[SQL-1];
  assign out_data_o.pitch       = out_lock ? sp_dq[SQL + ATL - 1] : pitch_a;
  assign out_data_o.bank        = out_lock ? 16'sd0 : bank_dq[SQL-1];
  assign out_data_o.gimbal_lock = out_lock;

endmodule
`default_nettype wire
